>>> sv/u8d_pkg.sv
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and constants of the UTF-8 stream decoder
// Item formats on both channels, byte classes between front and back, and
// the code point limits that the back end checks.
// ----------------------------------------------------------------------------
package u8d_pkg;

	// Status codes of a result item
	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_NUL = 2'd2;

	// Code point limits
	localparam logic [20:0] CP_MAX       = 21'h10FFFF;
	localparam logic [20:0] SURR_LO      = 21'h00D800;
	localparam logic [20:0] SURR_HI      = 21'h00DFFF;
	localparam logic [20:0] NONCHAR_LO   = 21'h00FDD0;
	localparam logic [20:0] NONCHAR_HI   = 21'h00FDEF;
	localparam logic [15:0] NONCHAR_FFFE = 16'hFFFE;
	localparam logic [15:0] NONCHAR_FFFF = 16'hFFFF;
	localparam logic [20:0] MIN_LEN2     = 21'h000080;
	localparam logic [20:0] MIN_LEN3     = 21'h000800;
	localparam logic [20:0] MIN_LEN4     = 21'h010000;

	localparam logic [2:0] LEN2 = 3'd2;
	localparam logic [2:0] LEN3 = 3'd3;
	localparam logic [2:0] LEN4 = 3'd4;
	localparam logic [2:0] LEN5 = 3'd5;
	localparam logic [2:0] LEN6 = 3'd6;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_end;
	} in_item_t;

	typedef struct packed {
		logic [20:0] code_point;
		logic [1:0]  status;
		logic        byte_held_back;
		logic        last_of_run;
	} out_item_t;

	// Byte classes found by the front end
	typedef enum logic [2:0] {
		K_NUL   = 3'd0,
		K_ASCII = 3'd1,
		K_LEAD  = 3'd2,
		K_CONT  = 3'd3,
		K_BAD   = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [2:0] len;     // form length for a lead byte
		logic [6:0] bits;    // payload bits of the byte, right aligned
		logic       at_end;
	} cls_item_t;

endpackage

>>> sv/u8d_front.sv
// ----------------------------------------------------------------------------
// u8d_front: byte classifier and item queue
// Classifies each accepted byte (NUL, ASCII, lead with form length,
// continuation, bad) and queues it for the decoding back end.
// ----------------------------------------------------------------------------
module u8d_front #(
	parameter int unsigned DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  u8d_pkg::in_item_t   byte_item,
	output logic                q_valid,
	input  logic                q_pop,
	output u8d_pkg::cls_item_t  q_item
);

	localparam int unsigned PW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	u8d_pkg::cls_item_t mem_q [DEPTH];
	u8d_pkg::cls_item_t cls;
	logic [PW-1:0]      head_q;
	logic [PW-1:0]      tail_q;
	logic [CW-1:0]      count_q;
	logic               push;
	logic               pop;
	logic [7:0]         b;

	always_comb begin
		b          = byte_item.data_byte;
		cls.kind   = u8d_pkg::K_BAD;
		cls.len    = '0;
		cls.bits   = '0;
		cls.at_end = byte_item.buffer_end;
		if (b == 8'd0) begin
			cls.kind = u8d_pkg::K_NUL;
		end else if (!b[7]) begin
			cls.kind = u8d_pkg::K_ASCII;
			cls.bits = b[6:0];
		end else if (!b[6]) begin
			cls.kind = u8d_pkg::K_CONT;
			cls.bits = {1'b0, b[5:0]};
		end else if (!b[5]) begin
			cls.kind = u8d_pkg::K_LEAD;
			cls.len  = u8d_pkg::LEN2;
			cls.bits = {2'b0, b[4:0]};
		end else if (!b[4]) begin
			cls.kind = u8d_pkg::K_LEAD;
			cls.len  = u8d_pkg::LEN3;
			cls.bits = {3'b0, b[3:0]};
		end else if (!b[3]) begin
			cls.kind = u8d_pkg::K_LEAD;
			cls.len  = u8d_pkg::LEN4;
			cls.bits = {4'b0, b[2:0]};
		end else if (!b[2]) begin
			cls.kind = u8d_pkg::K_LEAD;
			cls.len  = u8d_pkg::LEN5;
			cls.bits = {5'b0, b[1:0]};
		end else if (!b[1]) begin
			cls.kind = u8d_pkg::K_LEAD;
			cls.len  = u8d_pkg::LEN6;
			cls.bits = {6'b0, b[0]};
		end
	end

	assign byte_ready = (count_q != CW'(DEPTH));
	assign push       = byte_valid && byte_ready;
	assign q_valid    = (count_q != '0);
	assign pop        = q_pop && q_valid;
	assign q_item     = mem_q[head_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (pop) begin
				head_q <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			count_q <= count_q + CW'(push) - CW'(pop);
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count above depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count missed a push");

endmodule

>>> sv/u8d_back.sv
// ----------------------------------------------------------------------------
// u8d_back: form decoder and result register
// Holds the partial value of the open form, accumulates continuation bits,
// checks finished forms, and delivers up to two results per byte through an
// output register and one pending slot.
// ----------------------------------------------------------------------------
module u8d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	output logic                q_pop,
	input  u8d_pkg::cls_item_t  q_item,
	output logic                cp_valid,
	input  logic                cp_ready,
	output u8d_pkg::out_item_t  cp_item
);

	// Decoder state; big_q marks value bits shifted out above bit 20
	logic [20:0] acc_q;
	logic        big_q;
	logic [2:0]  rem_q;
	logic [2:0]  len_q;

	logic [20:0] acc_d;
	logic        big_d;
	logic [2:0]  rem_d;
	logic [2:0]  len_d;

	u8d_pkg::out_item_t out_q;
	logic               out_valid_q;
	u8d_pkg::out_item_t pend_q;
	logic               pend_valid_q;

	logic               load_ok;
	logic               pop;
	u8d_pkg::out_item_t l_res;
	logic               l_valid;
	logic               l_start;
	u8d_pkg::out_item_t r0;
	u8d_pkg::out_item_t r1;
	logic               v0;
	logic               v1;
	u8d_pkg::out_item_t err;
	logic [20:0]        acc_sh;
	logic               big_sh;
	logic [2:0]         rem_dec;
	logic               too_small;
	logic               cp_ok;

	assign load_ok = !out_valid_q || cp_ready;
	assign pop     = q_valid && load_ok && !pend_valid_q;
	assign q_pop   = pop;

	always_comb begin
		err             = '0;
		err.status      = u8d_pkg::ST_BAD;
		err.last_of_run = 1'b1;

		// Byte taken as a lead byte
		l_res             = '0;
		l_res.last_of_run = 1'b1;
		l_valid           = 1'b1;
		l_start           = 1'b0;
		case (q_item.kind)
			u8d_pkg::K_NUL: begin
				l_res.status = u8d_pkg::ST_NUL;
			end
			u8d_pkg::K_ASCII: begin
				l_res.status     = u8d_pkg::ST_OK;
				l_res.code_point = 21'(q_item.bits);
			end
			u8d_pkg::K_LEAD: begin
				if (q_item.at_end) begin
					l_res.status = u8d_pkg::ST_BAD;
				end else begin
					l_valid = 1'b0;
					l_start = 1'b1;
				end
			end
			default: begin
				l_res.status = u8d_pkg::ST_BAD;
			end
		endcase

		// Byte taken as a continuation byte
		acc_sh  = {acc_q[14:0], q_item.bits[5:0]};
		big_sh  = big_q || (acc_q[20:15] != '0);
		rem_dec = rem_q - 3'd1;
		case (len_q)
			u8d_pkg::LEN2: too_small = (acc_sh < u8d_pkg::MIN_LEN2) && (acc_sh != '0);
			u8d_pkg::LEN3: too_small = acc_sh < u8d_pkg::MIN_LEN3;
			u8d_pkg::LEN4: too_small = acc_sh < u8d_pkg::MIN_LEN4;
			default:       too_small = 1'b1;
		endcase
		cp_ok = !big_sh && (acc_sh <= u8d_pkg::CP_MAX)
			&& !((acc_sh >= u8d_pkg::SURR_LO) && (acc_sh <= u8d_pkg::SURR_HI))
			&& !((acc_sh >= u8d_pkg::NONCHAR_LO) && (acc_sh <= u8d_pkg::NONCHAR_HI))
			&& (acc_sh[15:0] != u8d_pkg::NONCHAR_FFFE)
			&& (acc_sh[15:0] != u8d_pkg::NONCHAR_FFFF)
			&& !too_small;

		r0    = '0;
		r1    = '0;
		v0    = 1'b0;
		v1    = 1'b0;
		acc_d = acc_q;
		big_d = big_q;
		rem_d = rem_q;
		len_d = len_q;

		if (pop) begin
			// Go idle by default; a lead byte that opens a form overrides
			acc_d = '0;
			big_d = 1'b0;
			rem_d = '0;
			len_d = '0;
			if (rem_q == '0 || q_item.kind != u8d_pkg::K_CONT) begin
				if (rem_q == '0) begin
					r0 = l_res;
					v0 = l_valid;
				end else begin
					// Broken form: report, then re-handle the byte as a lead
					r0                = err;
					r0.byte_held_back = 1'b1;
					r0.last_of_run    = !l_valid;
					v0                = 1'b1;
					r1                = l_res;
					v1                = l_valid;
				end
				if (l_start) begin
					acc_d = 21'(q_item.bits);
					rem_d = q_item.len - 3'd1;
					len_d = q_item.len;
				end
			end else if (rem_dec == '0) begin
				v0 = 1'b1;
				if (cp_ok) begin
					r0             = '0;
					r0.code_point  = acc_sh;
					r0.status      = u8d_pkg::ST_OK;
					r0.last_of_run = 1'b1;
				end else begin
					r0 = err;
				end
			end else if (q_item.at_end) begin
				r0 = err;
				v0 = 1'b1;
			end else begin
				acc_d = acc_sh;
				big_d = big_sh;
				rem_d = rem_dec;
				len_d = len_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else begin
				out_q  <= r0;
				pend_q <= r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			big_q        <= 1'b0;
			rem_q        <= '0;
			len_q        <= '0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			acc_q <= acc_d;
			big_q <= big_d;
			rem_q <= rem_d;
			len_q <= len_d;
			if (load_ok) begin
				if (pend_valid_q) begin
					out_valid_q  <= 1'b1;
					pend_valid_q <= 1'b0;
				end else begin
					out_valid_q  <= v0;
					pend_valid_q <= v1;
				end
			end
		end
	end

	assign cp_valid = out_valid_q;
	assign cp_item  = out_q;

	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> out_valid_q && out_q.byte_held_back && !out_q.last_of_run)
		else $error("pending result without its broken-form error ahead");

	a_zero_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != u8d_pkg::ST_OK |-> out_q.code_point == '0)
		else $error("nonzero code point on error result");

	a_form_state: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q != '0 |-> len_q >= u8d_pkg::LEN2 && rem_q < len_q)
		else $error("remaining count out of range for form length");

	a_no_pop_with_pend: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> !q_pop)
		else $error("queue popped while a second result is pending");

endmodule

>>> sv/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top: modified UTF-8 byte stream decoder
// Front end classifies and queues bytes; back end decodes forms and delivers
// code points or error and terminator results.
// ----------------------------------------------------------------------------
// Takes one byte per clock while the queue has room and gives one result per
// clock while the output side is ready. A byte is written into the classifier
// queue at acceptance; its result is loaded into the output register when the
// output side is ready. A byte breaking an open form that is an ASCII, NUL or
// bad byte, or a lead at the buffer end, gives two results, which leave the
// output register one after the other; the queue of QUEUE_DEPTH bytes absorbs
// the pause and any output stall, so the input side stalls only once the queue
// is full. Bytes that continue or open a form give no result until it ends.
module utf8_stream_decoder_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_ready,
	input  u8d_pkg::in_item_t   byte_item,
	output logic                cp_valid,
	input  logic                cp_ready,
	output u8d_pkg::out_item_t  cp_item
);

	logic               q_valid;
	logic               q_pop;
	u8d_pkg::cls_item_t q_item;

	u8d_front #(
		.DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_item     (q_item)
	);

	u8d_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_item   (q_item),
		.cp_valid (cp_valid),
		.cp_ready (cp_ready),
		.cp_item  (cp_item)
	);

endmodule

>>> dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for utf8_stream_decoder_top
// Feeds directed and random byte streams (well-formed forms, broken forms,
// cut-off forms, noise) through the byte channel. A local decoder model
// predicts every code point, error and terminator item, and a monitor
// compares each output item against the oldest prediction. The run sweeps
// several pacing phases on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned QUIET_LIMIT = 3000;
	localparam int unsigned PHASE_BYTES = 212;
	localparam int unsigned HOLD_CYCLES = 300;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               byte_valid = 1'b0;
	logic               byte_ready;
	u8d_pkg::in_item_t  byte_item  = '0;
	logic               cp_valid;
	logic               cp_ready   = 1'b0;
	u8d_pkg::out_item_t cp_item;

	// decoder model state
	logic [30:0] acc_bits  = '0;
	logic [2:0]  cont_left = '0;
	logic [2:0]  form_len  = '0;

	u8d_pkg::in_item_t  byte_backlog[$];
	u8d_pkg::out_item_t expected_cps[$];
	u8d_pkg::out_item_t oldest_cp;

	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_request   = 0;
	int unsigned hold_left      = 0;
	int unsigned quiet_cycles   = 0;
	int unsigned bytes_queued   = 0;
	int unsigned bytes_accepted = 0;
	int unsigned results_seen   = 0;
	int unsigned mismatches     = 0;
	int unsigned n_ok           = 0;
	int unsigned n_bad          = 0;
	int unsigned n_nul          = 0;
	int unsigned broken_forms   = 0;
	logic        byte_taken     = 1'b0;
	int unsigned phase;
	int unsigned phase_target;

	utf8_stream_decoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.byte_item (byte_item),
		.cp_valid  (cp_valid),
		.cp_ready  (cp_ready),
		.cp_item   (cp_item)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic u8d_pkg::out_item_t make_result(input logic [20:0] cp,
			input logic [1:0] st, input logic held, input logic last);
		u8d_pkg::out_item_t r;
		r.code_point     = cp;
		r.status         = st;
		r.byte_held_back = held;
		r.last_of_run    = last;
		return r;
	endfunction

	// Handle a byte in the idle state; return the number of items it produced.
	function automatic int start_or_emit(input logic [7:0] b, input logic at_end);
		logic [2:0] len;
		logic [6:0] bits;
		len  = 3'd0;
		bits = '0;
		if (b == 8'h00) begin
			expected_cps.push_back(make_result('0, u8d_pkg::ST_NUL, 1'b0, 1'b1));
			return 1;
		end
		if (!b[7]) begin
			expected_cps.push_back(make_result({13'd0, b}, u8d_pkg::ST_OK, 1'b0, 1'b1));
			return 1;
		end
		if (b[7:5] == 3'b110) begin
			len  = u8d_pkg::LEN2;
			bits = {2'b0, b[4:0]};
		end else if (b[7:4] == 4'b1110) begin
			len  = u8d_pkg::LEN3;
			bits = {3'b0, b[3:0]};
		end else if (b[7:3] == 5'b11110) begin
			len  = u8d_pkg::LEN4;
			bits = {4'b0, b[2:0]};
		end else if (b[7:2] == 6'b111110) begin
			len  = u8d_pkg::LEN5;
			bits = {5'b0, b[1:0]};
		end else if (b[7:1] == 7'b1111110) begin
			len  = u8d_pkg::LEN6;
			bits = {6'b0, b[0]};
		end
		// bad lead, or a lead with nothing after it in the buffer
		if (len == 3'd0 || at_end) begin
			expected_cps.push_back(make_result('0, u8d_pkg::ST_BAD, 1'b0, 1'b1));
			return 1;
		end
		acc_bits  = {24'd0, bits};
		cont_left = len - 3'd1;
		form_len  = len;
		return 0;
	endfunction

	function automatic void decode_byte(input u8d_pkg::in_item_t it);
		logic [7:0]  b;
		logic [31:0] cp;
		logic [31:0] floor_cp;
		logic        ok;
		b = it.data_byte;
		if (cont_left == 3'd0) begin
			void'(start_or_emit(b, it.buffer_end));
		end else if (b[7:6] != 2'b10) begin
			// broken form: error first, then re-handle the byte as a lead
			acc_bits  = '0;
			cont_left = '0;
			form_len  = '0;
			broken_forms++;
			expected_cps.push_back(make_result('0, u8d_pkg::ST_BAD, 1'b1, 1'b0));
			if (start_or_emit(b, it.buffer_end) == 0)
				expected_cps[expected_cps.size() - 1].last_of_run = 1'b1;
		end else begin
			acc_bits  = {acc_bits[24:0], b[5:0]};
			cont_left = cont_left - 3'd1;
			if (cont_left == 3'd0) begin
				cp = {1'b0, acc_bits};
				ok = 1'b1;
				if (cp > u8d_pkg::CP_MAX)
					ok = 1'b0;
				if (cp >= u8d_pkg::SURR_LO && cp <= u8d_pkg::SURR_HI)
					ok = 1'b0;
				if (cp >= u8d_pkg::NONCHAR_LO && cp <= u8d_pkg::NONCHAR_HI)
					ok = 1'b0;
				if (cp[15:0] == u8d_pkg::NONCHAR_FFFE || cp[15:0] == u8d_pkg::NONCHAR_FFFF)
					ok = 1'b0;
				case (form_len)
					u8d_pkg::LEN2: floor_cp = {11'd0, u8d_pkg::MIN_LEN2};
					u8d_pkg::LEN3: floor_cp = {11'd0, u8d_pkg::MIN_LEN3};
					u8d_pkg::LEN4: floor_cp = {11'd0, u8d_pkg::MIN_LEN4};
					u8d_pkg::LEN5: floor_cp = 32'h0020_0000;
					default: floor_cp = 32'h0400_0000;
				endcase
				// overlong, except the two-byte form of zero
				if (cp < floor_cp && !(cp == 32'd0 && form_len == u8d_pkg::LEN2))
					ok = 1'b0;
				acc_bits = '0;
				form_len = '0;
				if (ok)
					expected_cps.push_back(make_result(cp[20:0], u8d_pkg::ST_OK,
						1'b0, 1'b1));
				else
					expected_cps.push_back(make_result('0, u8d_pkg::ST_BAD, 1'b0, 1'b1));
			end else if (it.buffer_end) begin
				acc_bits  = '0;
				cont_left = '0;
				form_len  = '0;
				expected_cps.push_back(make_result('0, u8d_pkg::ST_BAD, 1'b0, 1'b1));
			end
		end
	endfunction

	task automatic queue_byte(input logic [7:0] b, input logic at_end);
		u8d_pkg::in_item_t it;
		it.data_byte  = b;
		it.buffer_end = at_end;
		byte_backlog.push_back(it);
		bytes_queued++;
	endtask

	function automatic logic end_flag();
		return $urandom_range(99) < 4;
	endfunction

	// Queue the first nbytes bytes of the len-byte encoding of cp.
	task automatic queue_form(input logic [31:0] cp, input int unsigned len,
			input int unsigned nbytes, input int unsigned end_pct);
		logic [7:0]  b;
		int unsigned i;
		for (i = 0; i < nbytes; i++) begin
			if (i == 0)
				b = (8'hFF << (8 - len)) | (8'(cp >> (6 * (len - 1))) & (8'hFF >> (len + 1)));
			else
				b = 8'h80 | (8'(cp >> (6 * (len - 1 - i))) & 8'h3F);
			queue_byte(b, $urandom_range(99) < end_pct);
		end
	endtask

	function automatic logic [31:0] boundary_cp(input int unsigned idx);
		case (idx)
			0:  return 32'h0000_0000;
			1:  return 32'h0000_007F;
			2:  return 32'h0000_0080;
			3:  return 32'h0000_07FF;
			4:  return 32'h0000_0800;
			5:  return 32'h0000_D7FF;
			6:  return 32'h0000_D800;
			7:  return 32'h0000_DFFF;
			8:  return 32'h0000_E000;
			9:  return 32'h0000_FDCF;
			10: return 32'h0000_FDD0;
			11: return 32'h0000_FDEF;
			12: return 32'h0000_FDF0;
			13: return 32'h0000_FFFD;
			14: return 32'h0000_FFFE;
			15: return 32'h0000_FFFF;
			16: return 32'h0001_0000;
			17: return 32'h0001_FFFF;
			18: return 32'h0010_FFFF;
			default: return 32'h0011_0000;
		endcase
	endfunction

	task automatic queue_random_chunk();
		int unsigned pick;
		int unsigned r;
		int unsigned len;
		int unsigned nb;
		logic [31:0] cp;
		logic [7:0]  brk;
		pick = $urandom_range(99);
		if (pick < 3) begin
			queue_byte(8'h00, end_flag());
		end else if (pick < 13) begin
			queue_byte(8'($urandom_range(127)), end_flag());
		end else if (pick < 82) begin
			r   = $urandom_range(99);
			len = (r < 30) ? 2 : (r < 60) ? 3 : (r < 90) ? 4 : (r < 95) ? 5 : 6;
			if ($urandom_range(1) == 0)
				cp = boundary_cp($urandom_range(19));
			else
				cp = $urandom();
			nb = (pick < 70) ? len : $urandom_range(len - 1, 1);
			queue_form(cp, len, nb, 3);
			if (pick >= 70) begin
				// break the form with a byte that is not a continuation
				case ($urandom_range(3))
					0: brk = 8'h00;
					1: brk = 8'($urandom_range(127, 1));
					2: brk = 8'($urandom_range(253, 192));
					default: brk = 8'($urandom_range(255, 254));
				endcase
				queue_byte(brk, end_flag());
			end
		end else begin
			queue_byte(8'($urandom_range(255)), end_flag());
		end
	endtask

	// acceptance on the byte channel feeds the model
	always @(posedge clk) begin
		byte_taken = arst_n && byte_valid && byte_ready;
		if (byte_taken) begin
			decode_byte(byte_item);
			bytes_accepted++;
		end
	end

	// byte driver
	always @(negedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else if (!byte_valid || byte_taken) begin
			if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				byte_item  <= byte_backlog.pop_front();
				byte_valid <= 1'b1;
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// output side ready, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (!arst_n) begin
			cp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left--;
			cp_ready <= 1'b0;
		end else begin
			cp_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && cp_valid && cp_ready) begin
			results_seen++;
			if (expected_cps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: cp=%h status=%0d held=%0b last=%0b",
						cp_item.code_point, cp_item.status, cp_item.byte_held_back,
						cp_item.last_of_run);
			end else begin
				oldest_cp = expected_cps.pop_front();
				case (oldest_cp.status)
					u8d_pkg::ST_OK:  n_ok++;
					u8d_pkg::ST_NUL: n_nul++;
					default:         n_bad++;
				endcase
				if (cp_item.code_point !== oldest_cp.code_point ||
						cp_item.status !== oldest_cp.status ||
						cp_item.byte_held_back !== oldest_cp.byte_held_back ||
						cp_item.last_of_run !== oldest_cp.last_of_run) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp cp=%h st=%0d held=%0b last=%0b, ",
							"got cp=%h st=%0d held=%0b last=%0b"},
							oldest_cp.code_point, oldest_cp.status, oldest_cp.byte_held_back,
							oldest_cp.last_of_run, cp_item.code_point, cp_item.status,
							cp_item.byte_held_back, cp_item.last_of_run);
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either channel
	always @(posedge clk) begin
		if (!arst_n || (byte_valid && byte_ready) || (cp_valid && cp_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: %0d items still expected", expected_cps.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: terminator, ASCII top, two-byte zero, overlong,
		// surrogate, noncharacter, top code point, a bad lead, a stray continuation, broken and cut forms
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_form(32'h0000_0000, 2, 2, 0);
		queue_form(32'h0000_007F, 2, 2, 0);
		queue_form(32'h0000_D800, 3, 3, 0);
		queue_form(32'h0000_FFFF, 3, 3, 0);
		queue_form(32'h0010_FFFF, 4, 4, 0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'hE2, 1'b0);
		queue_byte(8'h41, 1'b0);
		queue_byte(8'hC3, 1'b0);
		queue_byte(8'hF0, 1'b0);
		queue_byte(8'h90, 1'b1);
		queue_byte(8'hC3, 1'b1);

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 80;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 80;
				end
				default: begin
					send_idle_pct  = 35;
					recv_stall_pct = 35;
				end
			endcase
			phase_target = bytes_queued + PHASE_BYTES;
			while (bytes_queued < phase_target)
				queue_random_chunk();
			// back up the output so the queue fills and the byte side stalls
			if (phase == 0)
				hold_request = HOLD_CYCLES;
			while (bytes_accepted != bytes_queued)
				@(posedge clk);
		end

		while (expected_cps.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("Decoded %0d bytes over four pacing phases and one %0d-cycle output hold-off.",
			bytes_accepted, HOLD_CYCLES);
		$display({"Checked %0d items: %0d code points, %0d errors (%0d broken forms), ",
			"%0d NULs; %0d mismatches."},
			results_seen, n_ok, n_bad, broken_forms, n_nul, mismatches);
		if (mismatches == 0 && expected_cps.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
